// File: hdl/point_segment_nearest_unit_macros.svh
// Assertion helpers for the point/segment nearest-point RTL.
`ifndef POINT_SEGMENT_NEAREST_UNIT_MACROS_SVH
`define POINT_SEGMENT_NEAREST_UNIT_MACROS_SVH
`ifndef SYNTH
`define PSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PSN_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);
`else
`define PSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSN_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg)
`endif
`endif

// File: hdl/psn_pkg.sv
package psn_pkg;

	localparam int CW    = 32;             // coordinate width
	localparam int DW    = CW + 1;         // coordinate difference width
	localparam int PW    = 2 * DW;         // product of two differences
	localparam int NCH   = 3;              // chunks of the dot magnitude
	localparam int CHW   = (PW + NCH - 1) / NCH;
	localparam int NW    = PW + DW;        // projection numerator magnitude
	localparam int QB    = CW + 2;         // quotient bits
	localparam int OFFW  = QB + 2;         // signed projection offset
	localparam int XW    = QB + 3;         // unsaturated projected coordinate
	localparam int RTW   = DW + 1;         // square root bits
	localparam int SQW   = 2 * RTW;        // square root radicand
	localparam int REMW  = RTW + 3;        // square root remainder
	localparam int DISTW = CW + 1;
	localparam int CFGW  = 32;
	localparam int DIV_LAT = QB + 2;
	localparam int SQ_LAT  = RTW + 2;

	typedef enum logic [1:0] {
		KIND_PROJ  = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2,
		KIND_MID   = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] query_x;
		logic signed [CW-1:0] query_y;
		logic                 clamp_to_segment;
		logic                 construction_line;
	} psn_in_t;

	typedef struct packed {
		logic signed [CW-1:0] nearest_x;
		logic signed [CW-1:0] nearest_y;
		logic [DISTW-1:0]     distance;
		kind_t                case_kind;
	} psn_out_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] query_x;
		logic signed [CW-1:0] query_y;
		logic signed [CW-1:0] mid_x;
		logic signed [CW-1:0] mid_y;
		logic                 clamp_en;
		logic                 degen;
		logic                 use_end;
	} psn_div_sb_t;

	typedef struct packed {
		logic [NW-1:0] num_x;
		logic          neg_x;
		logic [NW-1:0] num_y;
		logic          neg_y;
		logic [PW-1:0] den;
		psn_div_sb_t   sb;
	} psn_div_in_t;

	typedef struct packed {
		logic signed [OFFW-1:0] off_x;
		logic signed [OFFW-1:0] off_y;
		psn_div_sb_t            sb;
	} psn_div_out_t;

	typedef struct packed {
		logic signed [CW-1:0] nearest_x;
		logic signed [CW-1:0] nearest_y;
		kind_t                case_kind;
	} psn_sq_sb_t;

	function automatic logic signed [DW-1:0] sext(input logic [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

	function automatic logic signed [XW-1:0] xext(input logic [CW-1:0] v);
		return {{(XW-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic signed [CW-1:0] sat_coord(input logic [XW-1:0] v);
		logic [XW-CW:0] top;
		top = v[XW-1:CW-1];
		if (top == '0 || top == '1)
			return v[CW-1:0];
		else if (v[XW-1])
			return {1'b1, {(CW-1){1'b0}}};
		else
			return {1'b0, {(CW-1){1'b1}}};
	endfunction

endpackage

// File: hdl/psn_div_pipe.sv
module psn_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  psn_pkg::psn_div_in_t din,
	output logic                 out_valid,
	output psn_pkg::psn_div_out_t dout
);
	import psn_pkg::*;

	logic [QB:0]      vld_s;
	logic [NW-1:0]    rem_x_s [QB+1];
	logic [NW-1:0]    rem_y_s [QB+1];
	logic [QB-1:0]    quo_x_s [QB+1];
	logic [QB-1:0]    quo_y_s [QB+1];
	logic [PW-1:0]    den_s   [QB+1];
	logic             neg_x_s [QB+1];
	logic             neg_y_s [QB+1];
	psn_div_sb_t      sb_s    [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[QB-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		rem_x_s[0] <= din.num_x;
		rem_y_s[0] <= din.num_y;
		quo_x_s[0] <= '0;
		quo_y_s[0] <= '0;
		den_s[0]   <= din.den;
		neg_x_s[0] <= din.neg_x;
		neg_y_s[0] <= din.neg_y;
		sb_s[0]    <= din.sb;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [NW-1:0] trial;
		logic          ge_x;
		logic          ge_y;

		assign trial = NW'(den_s[k]) << SH;
		assign ge_x  = rem_x_s[k] >= trial;
		assign ge_y  = rem_y_s[k] >= trial;

		always_ff @(posedge clk) begin
			rem_x_s[k+1] <= ge_x ? rem_x_s[k] - trial : rem_x_s[k];
			rem_y_s[k+1] <= ge_y ? rem_y_s[k] - trial : rem_y_s[k];
			quo_x_s[k+1] <= quo_x_s[k] | (QB'(ge_x) << SH);
			quo_y_s[k+1] <= quo_y_s[k] | (QB'(ge_y) << SH);
			den_s[k+1]   <= den_s[k];
			neg_x_s[k+1] <= neg_x_s[k];
			neg_y_s[k+1] <= neg_y_s[k];
			sb_s[k+1]    <= sb_s[k];
		end
	end

	// round half away from zero on the magnitude, then apply the sign
	logic [QB:0]   mag_x, mag_y;
	logic [OFFW-1:0] ext_x, ext_y;

	always_comb begin
		mag_x = {1'b0, quo_x_s[QB]} +
			(QB+1)'(({rem_x_s[QB], 1'b0}) >= (NW+1)'(den_s[QB]));
		mag_y = {1'b0, quo_y_s[QB]} +
			(QB+1)'(({rem_y_s[QB], 1'b0}) >= (NW+1)'(den_s[QB]));
		ext_x = OFFW'(mag_x);
		ext_y = OFFW'(mag_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= vld_s[QB];
	end

	always_ff @(posedge clk) begin
		dout.off_x <= neg_x_s[QB] ? -ext_x : ext_x;
		dout.off_y <= neg_y_s[QB] ? -ext_y : ext_y;
		dout.sb    <= sb_s[QB];
	end

endmodule

// File: hdl/psn_sqrt_pipe.sv
module psn_sqrt_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [psn_pkg::SQW-1:0]   radicand,
	input  psn_pkg::psn_sq_sb_t       sb_in,
	output logic                      out_valid,
	output psn_pkg::psn_out_t         dout
);
	import psn_pkg::*;

	logic [RTW:0]     vld_s;
	logic [SQW-1:0]   n_s    [RTW+1];
	logic [REMW-1:0]  rem_s  [RTW+1];
	logic [RTW-1:0]   root_s [RTW+1];
	psn_sq_sb_t       sb_s   [RTW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[RTW-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		n_s[0]    <= radicand;
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		sb_s[0]   <= sb_in;
	end

	// digit-by-digit root: bring down two radicand bits per stage
	for (genvar k = 0; k < RTW; k++) begin : g_step
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		logic            ge;

		assign rem_sh = {rem_s[k][REMW-3:0], n_s[k][SQW-1-2*k -: 2]};
		assign trial  = REMW'({root_s[k], 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			n_s[k+1]    <= n_s[k];
			rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
			root_s[k+1] <= {root_s[k][RTW-2:0], ge};
			sb_s[k+1]   <= sb_s[k];
		end
	end

	logic [RTW:0] rnd;

	always_comb begin
		rnd = {1'b0, root_s[RTW]} + (RTW+1)'(rem_s[RTW] > REMW'(root_s[RTW]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= vld_s[RTW];
	end

	always_ff @(posedge clk) begin
		dout.nearest_x <= sb_s[RTW].nearest_x;
		dout.nearest_y <= sb_s[RTW].nearest_y;
		dout.case_kind <= sb_s[RTW].case_kind;
		// saturate to the distance field
		dout.distance  <= (rnd[RTW:DISTW] != '0) ? '1 : rnd[DISTW-1:0];
	end

endmodule

// File: hdl/point_segment_nearest_unit.sv
// Nearest point on a segment (or its line) to a query point, fixed point throughout.
// Fully pipelined: one transaction may start every cycle, busy stays low, and the result
// appears on result with result_valid. The depth comes from the 34-step projection divider
// and the 34-step square root for the distance; the receiver cannot stall, so nothing in
// the pipeline ever holds. min_length_squared is written through cfg_wr_en/cfg_wr_data and
// must only change while the pipe is empty.
`include "point_segment_nearest_unit_macros.svh"

module point_segment_nearest_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [psn_pkg::CFGW-1:0]   cfg_wr_data,
	input  logic                       start,
	output logic                       busy,
	input  psn_pkg::psn_in_t           request,
	output logic                       result_valid,
	output psn_pkg::psn_out_t          result
);
	import psn_pkg::*;

	localparam int LAT = 10 + DIV_LAT + SQ_LAT;

	logic [CFGW-1:0] mls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mls_q <= CFGW'(1);
		else if (cfg_wr_en)
			mls_q <= cfg_wr_data;
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= div_vld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// stage 1: differences and midpoint
	logic signed [DW-1:0] mid_sum_x, mid_sum_y;
	logic signed [DW-1:0] dx_s1, dy_s1, ax_s1, ay_s1, bx_s1, by_s1;
	psn_div_sb_t          sb_s1;

	always_comb begin
		mid_sum_x = sext(request.start_x) + sext(request.end_x);
		mid_sum_y = sext(request.start_y) + sext(request.end_y);
	end

	always_ff @(posedge clk) begin
		dx_s1 <= sext(request.end_x) - sext(request.start_x);
		dy_s1 <= sext(request.end_y) - sext(request.start_y);
		ax_s1 <= sext(request.query_x) - sext(request.start_x);
		ay_s1 <= sext(request.query_y) - sext(request.start_y);
		bx_s1 <= sext(request.end_x) - sext(request.query_x);
		by_s1 <= sext(request.end_y) - sext(request.query_y);
		sb_s1.start_x  <= request.start_x;
		sb_s1.start_y  <= request.start_y;
		sb_s1.end_x    <= request.end_x;
		sb_s1.end_y    <= request.end_y;
		sb_s1.query_x  <= request.query_x;
		sb_s1.query_y  <= request.query_y;
		sb_s1.mid_x    <= mid_sum_x[DW-1:1];
		sb_s1.mid_y    <= mid_sum_y[DW-1:1];
		sb_s1.clamp_en <= request.clamp_to_segment && !request.construction_line;
		sb_s1.degen    <= 1'b0;
		sb_s1.use_end  <= 1'b0;
	end

	// stage 2: products
	logic signed [PW-1:0] pdxx_s2, pdyy_s2, pdot_x_s2, pdot_y_s2;
	logic signed [PW-1:0] paa_x_s2, paa_y_s2, pbb_x_s2, pbb_y_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	psn_div_sb_t          sb_s2;

	always_ff @(posedge clk) begin
		pdxx_s2   <= dx_s1 * dx_s1;
		pdyy_s2   <= dy_s1 * dy_s1;
		pdot_x_s2 <= ax_s1 * dx_s1;
		pdot_y_s2 <= ay_s1 * dy_s1;
		paa_x_s2  <= ax_s1 * ax_s1;
		paa_y_s2  <= ay_s1 * ay_s1;
		pbb_x_s2  <= bx_s1 * bx_s1;
		pbb_y_s2  <= by_s1 * by_s1;
		dx_s2     <= dx_s1;
		dy_s2     <= dy_s1;
		sb_s2     <= sb_s1;
	end

	// stage 3: sums
	logic [PW-1:0]        len2_s3, d1_s3, d2_s3;
	logic [PW:0]          dot_s3;
	logic signed [DW-1:0] dx_s3, dy_s3;
	psn_div_sb_t          sb_s3;

	always_ff @(posedge clk) begin
		len2_s3 <= $unsigned(pdxx_s2) + $unsigned(pdyy_s2);
		d1_s3   <= $unsigned(paa_x_s2) + $unsigned(paa_y_s2);
		d2_s3   <= $unsigned(pbb_x_s2) + $unsigned(pbb_y_s2);
		dot_s3  <= {pdot_x_s2[PW-1], pdot_x_s2} + {pdot_y_s2[PW-1], pdot_y_s2};
		dx_s3   <= dx_s2;
		dy_s3   <= dy_s2;
		sb_s3   <= sb_s2;
	end

	// stage 4: magnitudes, degenerate test, endpoint choice
	logic [PW:0]   dot_abs;
	logic [DW-1:0] dx_abs, dy_abs;
	psn_div_sb_t   sb_next;
	logic [PW-1:0] dot_mag_s4, len2_s4;
	logic [DW-1:0] dxm_s4, dym_s4;
	logic          neg_x_s4, neg_y_s4;
	psn_div_sb_t   sb_s4;

	always_comb begin
		dot_abs = dot_s3[PW] ? (~dot_s3 + 1'b1) : dot_s3;
		dx_abs  = dx_s3[DW-1] ? (~dx_s3 + 1'b1) : dx_s3;
		dy_abs  = dy_s3[DW-1] ? (~dy_s3 + 1'b1) : dy_s3;
		sb_next         = sb_s3;
		sb_next.degen   = (len2_s3 == '0) || (len2_s3 < PW'(mls_q));
		sb_next.use_end = d2_s3 < d1_s3;
	end

	always_ff @(posedge clk) begin
		dot_mag_s4 <= dot_abs[PW-1:0];
		dxm_s4     <= dx_abs;
		dym_s4     <= dy_abs;
		neg_x_s4   <= dot_s3[PW] ^ dx_s3[DW-1];
		neg_y_s4   <= dot_s3[PW] ^ dy_s3[DW-1];
		len2_s4    <= len2_s3;
		sb_s4      <= sb_next;
	end

	// stage 5: partial products of the numerator
	logic [NCH*CHW-1:0]   dot_pad;
	logic [CHW+DW-1:0]    ppx_s5 [NCH];
	logic [CHW+DW-1:0]    ppy_s5 [NCH];
	logic [PW-1:0]        len2_s5;
	logic                 neg_x_s5, neg_y_s5;
	psn_div_sb_t          sb_s5;

	assign dot_pad = (NCH*CHW)'(dot_mag_s4);

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			ppx_s5[c] <= dot_pad[c*CHW +: CHW] * dxm_s4;
			ppy_s5[c] <= dot_pad[c*CHW +: CHW] * dym_s4;
		end
		len2_s5  <= len2_s4;
		neg_x_s5 <= neg_x_s4;
		neg_y_s5 <= neg_y_s4;
		sb_s5    <= sb_s4;
	end

	// stage 6: numerator assembly into the divider input
	logic [NW-1:0] num_x, num_y;
	psn_div_in_t   div_in_s6;

	always_comb begin
		num_x = '0;
		num_y = '0;
		for (int c = 0; c < NCH; c++) begin
			num_x = num_x + (NW'(ppx_s5[c]) << (c*CHW));
			num_y = num_y + (NW'(ppy_s5[c]) << (c*CHW));
		end
	end

	always_ff @(posedge clk) begin
		div_in_s6.num_x <= num_x;
		div_in_s6.neg_x <= neg_x_s5;
		div_in_s6.num_y <= num_y;
		div_in_s6.neg_y <= neg_y_s5;
		div_in_s6.den   <= len2_s5;
		div_in_s6.sb    <= sb_s5;
	end

	psn_div_out_t div_out;

	psn_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.din       (div_in_s6),
		.out_valid (div_vld),
		.dout      (div_out)
	);

	// stage 7: bounding box test and selection
	logic signed [XW-1:0] rx, ry, lox, hix, loy, hiy;
	logic                 in_box;
	logic signed [CW-1:0] px, py;
	kind_t                kind;

	always_comb begin
		rx = xext(div_out.sb.start_x) + XW'(div_out.off_x);
		ry = xext(div_out.sb.start_y) + XW'(div_out.off_y);
		if ($signed(div_out.sb.start_x) < $signed(div_out.sb.end_x)) begin
			lox = xext(div_out.sb.start_x);
			hix = xext(div_out.sb.end_x);
		end else begin
			lox = xext(div_out.sb.end_x);
			hix = xext(div_out.sb.start_x);
		end
		if ($signed(div_out.sb.start_y) < $signed(div_out.sb.end_y)) begin
			loy = xext(div_out.sb.start_y);
			hiy = xext(div_out.sb.end_y);
		end else begin
			loy = xext(div_out.sb.end_y);
			hiy = xext(div_out.sb.start_y);
		end
		in_box = (rx >= lox) && (rx <= hix) && (ry >= loy) && (ry <= hiy);

		if (div_out.sb.degen) begin
			px   = div_out.sb.mid_x;
			py   = div_out.sb.mid_y;
			kind = KIND_MID;
		end else if (div_out.sb.clamp_en && !in_box) begin
			if (div_out.sb.use_end) begin
				px   = div_out.sb.end_x;
				py   = div_out.sb.end_y;
				kind = KIND_END;
			end else begin
				px   = div_out.sb.start_x;
				py   = div_out.sb.start_y;
				kind = KIND_START;
			end
		end else begin
			px   = sat_coord(rx);
			py   = sat_coord(ry);
			kind = KIND_PROJ;
		end
	end

	logic signed [CW-1:0] px_s7, py_s7, qx_s7, qy_s7;
	kind_t                kind_s7;
	logic                 clamp_s7;

	always_ff @(posedge clk) begin
		px_s7    <= px;
		py_s7    <= py;
		kind_s7  <= kind;
		qx_s7    <= div_out.sb.query_x;
		qy_s7    <= div_out.sb.query_y;
		clamp_s7 <= div_out.sb.clamp_en;
	end

	// stages 8 to 10: squared distance to the chosen point
	logic signed [DW-1:0] ddx_s8, ddy_s8;
	psn_sq_sb_t           sb_s8, sb_s9, sb_s10;
	logic signed [PW-1:0] sqx_s9, sqy_s9;
	logic [SQW-1:0]       nsq_s10;

	always_ff @(posedge clk) begin
		ddx_s8           <= sext(qx_s7) - sext(px_s7);
		ddy_s8           <= sext(qy_s7) - sext(py_s7);
		sb_s8.nearest_x  <= px_s7;
		sb_s8.nearest_y  <= py_s7;
		sb_s8.case_kind  <= kind_s7;
		sqx_s9           <= ddx_s8 * ddx_s8;
		sqy_s9           <= ddy_s8 * ddy_s8;
		sb_s9            <= sb_s8;
		nsq_s10          <= SQW'($unsigned(sqx_s9)) + SQW'($unsigned(sqy_s9));
		sb_s10           <= sb_s9;
	end

	psn_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s10),
		.radicand  (nsq_s10),
		.sb_in     (sb_s10),
		.out_valid (result_valid),
		.dout      (result)
	);

	`PSN_ASSERT_DLY(a_latency, clk, arst_n, accept, LAT, result_valid, "result missing")
	`PSN_ASSERT_IMP(a_no_extra, clk, arst_n, result_valid, $past(accept, LAT), "unexpected result")
	`PSN_ASSERT_IMP(a_clamp_only, clk, arst_n,
		vld_s7 && (kind_s7 == KIND_START || kind_s7 == KIND_END), clamp_s7,
		"endpoint chosen without clamping")

endmodule

// File: verif/tb.sv
module tb;
	import psn_pkg::*;

	localparam int PIPE_DEPTH = 82;

	class nearest_point_scoreboard;
		psn_out_t pending[$];
		logic [CFGW-1:0] min_len_sq;
		int errors;

		function new();
			min_len_sq = 1;
			errors = 0;
		endfunction

		// round(num / den), ties away from zero, magnitude capped at 2^62
		function automatic logic signed [191:0] div_round(logic signed [191:0] num,
			logic signed [191:0] den);
			logic [191:0] mag, q, r;
			logic neg;
			neg = num < 0;
			mag = neg ? -num : num;
			q = mag / den;
			r = mag % den;
			if ((r << 1) >= den)
				q = q + 1;
			if (q > (192'd1 << 62))
				q = 192'd1 << 62;
			return neg ? -$signed(q) : $signed(q);
		endfunction

		function automatic logic [63:0] root_round(logic [191:0] n);
			logic [191:0] r, c;
			r = 0;
			for (int b = 40; b >= 0; b--) begin
				c = r | (192'd1 << b);
				if (c * c <= n)
					r = c;
			end
			if (n - r * r > r)
				r = r + 1;
			return r[63:0];
		endfunction

		function automatic logic signed [191:0] sat(logic signed [191:0] v);
			if (v > 192'sd2147483647)
				return 192'sd2147483647;
			if (v < -192'sd2147483648)
				return -192'sd2147483648;
			return v;
		endfunction

		function void note_request(psn_in_t req);
			logic signed [191:0] sx, sy, ex, ey, qx, qy, dx, dy, len2, dot;
			logic signed [191:0] rx, ry, px, py, d1, d2;
			logic [191:0] dist_sq;
			logic [63:0] dist_val;
			logic in_box;
			psn_out_t exp_res;
			sx = req.start_x; sy = req.start_y;
			ex = req.end_x;   ey = req.end_y;
			qx = req.query_x; qy = req.query_y;
			dx = ex - sx;
			dy = ey - sy;
			len2 = dx * dx + dy * dy;
			if (len2 == 0 || len2 < $signed({160'd0, min_len_sq})) begin
				px = (sx + ex) >>> 1;
				py = (sy + ey) >>> 1;
				exp_res.case_kind = KIND_MID;
			end else begin
				dot = (qx - sx) * dx + (qy - sy) * dy;
				rx = sx + div_round(dot * dx, len2);
				ry = sy + div_round(dot * dy, len2);
				in_box = rx >= (sx < ex ? sx : ex) && rx <= (sx < ex ? ex : sx) &&
					ry >= (sy < ey ? sy : ey) && ry <= (sy < ey ? ey : sy);
				if (req.clamp_to_segment && !req.construction_line && !in_box) begin
					d1 = (sx - qx) * (sx - qx) + (sy - qy) * (sy - qy);
					d2 = (ex - qx) * (ex - qx) + (ey - qy) * (ey - qy);
					if (d2 < d1) begin
						px = ex; py = ey; exp_res.case_kind = KIND_END;
					end else begin
						px = sx; py = sy; exp_res.case_kind = KIND_START;
					end
				end else begin
					px = sat(rx);
					py = sat(ry);
					exp_res.case_kind = KIND_PROJ;
				end
			end
			dist_sq = (qx - px) * (qx - px) + (qy - py) * (qy - py);
			dist_val = root_round(dist_sq);
			if (dist_val > 64'h1_FFFF_FFFF)
				dist_val = 64'h1_FFFF_FFFF;
			exp_res.nearest_x = px[CW-1:0];
			exp_res.nearest_y = py[CW-1:0];
			exp_res.distance = dist_val[DISTW-1:0];
			pending = {pending, exp_res};
		endfunction

		function void check_result(psn_out_t got);
			psn_out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.nearest_x !== want.nearest_x || got.nearest_y !== want.nearest_y ||
				got.distance !== want.distance || got.case_kind !== want.case_kind) begin
				$display("%0t: mismatch expected x=%h y=%h d=%h k=%0d actual x=%h y=%h d=%h k=%0d",
					$time, want.nearest_x, want.nearest_y, want.distance, want.case_kind,
					got.nearest_x, got.nearest_y, got.distance, got.case_kind);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFGW-1:0] cfg_wr_data;
	logic start;
	logic busy;
	psn_in_t request;
	logic result_valid;
	psn_out_t result;
	logic busy_at_edge;
	logic no_gaps;

	nearest_point_scoreboard nearest_sb;

	point_segment_nearest_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// busy only moves at the rising edge, so the value at the falling edge is what the
	// next rising edge sees
	always @(negedge clk)
		busy_at_edge <= busy;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				nearest_sb.min_len_sq = cfg_wr_data;
			if (start && !busy)
				nearest_sb.note_request(request);
			if (result_valid)
				nearest_sb.check_result(result);
		end
	end

	task automatic send_segment(psn_in_t item);
		int gap;
		request <= item;
		start <= 1'b1;
		@(posedge clk);
		while (busy_at_edge)
			@(posedge clk);
		gap = 0;
		if (!no_gaps && $urandom_range(0, 9) < 2)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (nearest_sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_min_length(logic [CFGW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 2000)) - 1000;
			2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
				: 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic psn_in_t rand_segment();
		psn_in_t it;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 3) mode = 0;
		else if (mode < 6) mode = 1;
		else if (mode < 9) mode = 2;
		else mode = 3;
		it.start_x = rand_coord(mode);
		it.start_y = rand_coord(mode);
		it.end_x = rand_coord(mode);
		it.end_y = rand_coord(mode);
		it.query_x = rand_coord($urandom_range(0, 4) == 0 ? 0 : mode);
		it.query_y = rand_coord($urandom_range(0, 4) == 0 ? 0 : mode);
		// short segments to hit the degenerate threshold
		if ($urandom_range(0, 9) == 0) begin
			it.end_x = it.start_x + $signed($urandom_range(0, 6)) - 3;
			it.end_y = it.start_y + $signed($urandom_range(0, 6)) - 3;
		end
		it.clamp_to_segment = $urandom_range(0, 3) != 0;
		it.construction_line = $urandom_range(0, 3) == 0;
		return it;
	endfunction

	function automatic psn_in_t mk(int sx, int sy, int ex, int ey, int qx, int qy,
		bit cl, bit cn);
		psn_in_t it;
		it.start_x = sx; it.start_y = sy; it.end_x = ex; it.end_y = ey;
		it.query_x = qx; it.query_y = qy;
		it.clamp_to_segment = cl; it.construction_line = cn;
		return it;
	endfunction

	initial begin
		int mx, mn;
		logic [CFGW-1:0] settings[5];
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		nearest_sb = new();
		no_gaps = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		request = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_segment(mk(mx, mx, mx, mx, mx, mx, 1, 0));
		send_segment(mk(mn, mn, mn, mn, mn, mn, 1, 0));
		send_segment(mk(mn, mn, mx, mx, mx, mn, 1, 0));
		send_segment(mk(mn, mn, mx, mx, mn, mx, 0, 1));
		send_segment(mk(mn, mx, mx, mn, mx, mx, 1, 1));
		send_segment(mk(mn, 0, mx, 0, 0, mx, 1, 0));
		send_segment(mk(5, 7, 5, 7, 100, -3, 1, 0));
		send_segment(mk(-3, -4, -3, -4, mx, mn, 0, 0));
		send_segment(mk(-3, 0, 0, 0, 0, 0, 1, 0));
		send_segment(mk(0, 0, 2, 2, 1, 0, 1, 0));
		send_segment(mk(0, 0, 2, 2, -1, 0, 1, 0));
		send_segment(mk(0, 0, 2, 2, -1, 0, 0, 0));
		send_segment(mk(0, 0, 1000, 0, -50, 10, 1, 0));
		send_segment(mk(0, 0, 1000, 0, 1050, 10, 1, 0));
		send_segment(mk(0, 0, 1000, 0, 1050, 10, 1, 1));
		send_segment(mk(0, 0, 1000, 0, 1050, 10, 0, 0));
		send_segment(mk(-100, 0, 100, 0, 0, 500, 1, 0));
		send_segment(mk(mx, mx, mx - 1, mn, mn, mx, 0, 0));
		send_segment(mk(mn, mn, mn + 1, mx, mx, mn, 0, 1));
		send_segment(mk(mx, 0, mx, 10, mx, 5, 1, 0));
		send_segment(mk(-1, -1, 0, 0, 7, 7, 1, 0));
		drain_pipe();

		settings[0] = 32'd0;
		settings[1] = 32'hFFFF_FFFF;
		settings[2] = $urandom_range(2, 64);
		settings[3] = $urandom();
		settings[4] = 32'd1;
		for (int ph = 0; ph < 5; ph++) begin
			write_min_length(settings[ph]);
			for (int i = 0; i < 350; i++) begin
				if (ph == 4 && i >= 200)
					no_gaps = 1'b1;
				send_segment(rand_segment());
				// pause until the pipe empties once mid-phase
				if (ph == 2 && i == 170)
					drain_pipe();
			end
			drain_pipe();
		end

		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (nearest_sb.pending.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, nearest_sb.pending.size());
			nearest_sb.errors++;
		end
		if (nearest_sb.errors == 0)
			$display("point_segment_nearest_unit verification clean");
		else
			$display("point_segment_nearest_unit verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("point_segment_nearest_unit verification failed");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hdl
hdl/psn_pkg.sv
hdl/psn_div_pipe.sv
hdl/psn_sqrt_pipe.sv
hdl/point_segment_nearest_unit.sv
verif/tb.sv
